FILE: rtl/pcpa_pkg.sv
package pcpa_pkg;

    localparam int NUM_CPUS   = 8;
    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W     = 40;
    localparam int CPU_W      = $clog2(NUM_CPUS);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PG_W       = ADDR_W - PAGE_SHIFT;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int LINK_W     = IDX_W + 1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_link;

    typedef struct packed {
        logic             en;
        logic [CPU_W-1:0] cpu;
        t_link            head;
    } t_head_wr;

    typedef struct packed {
        logic             found;
        logic [CPU_W-1:0] src;
        logic [IDX_W-1:0] idx;
        t_link            own;
    } t_head_pick;

endpackage

FILE: rtl/pcpa_link_ram.sv
module pcpa_link_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pcpa_addr_unit.sv
module pcpa_addr_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcpa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic [pcpa_pkg::ADDR_W-1:0]    i_page_addr,
    input  logic [pcpa_pkg::IDX_W-1:0]     i_pop_idx,
    output logic                           o_bad,
    output logic [pcpa_pkg::IDX_W-1:0]     o_idx,
    output logic [pcpa_pkg::ADDR_W-1:0]    o_alloc_addr
);

    logic [pcpa_pkg::ADDR_W-1:0] r_start;
    logic [pcpa_pkg::ADDR_W-1:0] r_end;
    logic [pcpa_pkg::PG_W:0]     r_base;
    logic [pcpa_pkg::PG_W:0]     diff;
    logic [pcpa_pkg::PG_W-1:0]   pop_page;
    logic                        misaligned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_base  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pcpa_pkg::CFG_REGION_START) begin
                r_start <= i_cfg_data;
                r_base  <= {1'b0, i_cfg_data[pcpa_pkg::ADDR_W-1:pcpa_pkg::PAGE_SHIFT]}
                         + {{pcpa_pkg::PG_W{1'b0}},
                            |i_cfg_data[pcpa_pkg::PAGE_SHIFT-1:0]};
            end else if (i_cfg_idx == pcpa_pkg::CFG_REGION_END) begin
                r_end <= i_cfg_data;
            end
        end
    end

    assign misaligned = |i_page_addr[pcpa_pkg::PAGE_SHIFT-1:0];
    assign diff = {1'b0, i_page_addr[pcpa_pkg::ADDR_W-1:pcpa_pkg::PAGE_SHIFT]} - r_base;

    assign o_bad = misaligned || (i_page_addr < r_start) || (i_page_addr >= r_end)
                || (|diff[pcpa_pkg::PG_W:pcpa_pkg::IDX_W]);
    assign o_idx = diff[pcpa_pkg::IDX_W-1:0];

    assign pop_page = r_base[pcpa_pkg::PG_W-1:0]
                    + {{(pcpa_pkg::PG_W-pcpa_pkg::IDX_W){1'b0}}, i_pop_idx};
    assign o_alloc_addr = {pop_page, {pcpa_pkg::PAGE_SHIFT{1'b0}}};

endmodule

FILE: rtl/pcpa_head_table.sv
module pcpa_head_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pcpa_pkg::CPU_W-1:0] i_cpu,
    input  pcpa_pkg::t_head_wr         i_wr,
    output pcpa_pkg::t_head_pick       o_pick
);

    logic [pcpa_pkg::NUM_CPUS-1:0] r_vld;
    logic [pcpa_pkg::IDX_W-1:0]    r_idx [pcpa_pkg::NUM_CPUS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.cpu] <= i_wr.head.vld;
        end
        if (i_wr.en) begin
            r_idx[i_wr.cpu] <= i_wr.head.idx;
        end
    end

    // round-robin pick: own list first, then the following CPUs
    always_comb begin
        logic [pcpa_pkg::CPU_W-1:0] sel;
        o_pick.found = 1'b0;
        o_pick.src   = i_cpu;
        for (int k = pcpa_pkg::NUM_CPUS - 1; k >= 0; k--) begin
            sel = i_cpu + pcpa_pkg::CPU_W'(k);
            if (r_vld[sel]) begin
                o_pick.found = 1'b1;
                o_pick.src   = sel;
            end
        end
        o_pick.idx      = r_idx[o_pick.src];
        o_pick.own.vld  = r_vld[i_cpu];
        o_pick.own.idx  = r_idx[i_cpu];
    end

endmodule

FILE: rtl/per_cpu_page_allocator_steal.sv
// channel  direction  handshake                   payload
// request  in         i_in_valid / o_in_ready     i_req_type, i_cpu_id, i_page_addr
// result   out        o_out_valid / i_out_ready   o_alloc_addr, o_status, o_served_cpu
// config   in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A free, a rejected free or an out-of-memory alloc loads its result in the lookup step;
// an alloc that finds a page loads it in a pop step after that, waiting on the link memory read.
// The lookup step waits while the result register is full and not being taken.
// A new request is taken in the cycle that the current one completes.
// Reset empties all lists at once; the link memory is not cleared.
module per_cpu_page_allocator_steal (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcpa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [pcpa_pkg::CPU_W-1:0]     i_cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0]    i_page_addr,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pcpa_pkg::ADDR_W-1:0]    o_alloc_addr,
    output logic [pcpa_pkg::STATUS_W-1:0]  o_status,
    output logic [pcpa_pkg::CPU_W-1:0]     o_served_cpu
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_POP
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_req_type, n_req_type;
    logic [pcpa_pkg::CPU_W-1:0]      r_cpu, n_cpu;
    logic [pcpa_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [pcpa_pkg::CPU_W-1:0]      r_pop_src, n_pop_src;
    logic [pcpa_pkg::IDX_W-1:0]      r_pop_idx, n_pop_idx;
    logic                            r_out_vld, n_out_vld;
    logic [pcpa_pkg::ADDR_W-1:0]     r_out_addr, n_out_addr;
    logic [pcpa_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [pcpa_pkg::CPU_W-1:0]      r_out_served, n_out_served;

    pcpa_pkg::t_head_wr              head_wr;
    pcpa_pkg::t_head_pick            pick;
    logic                            ram_we;
    logic [pcpa_pkg::IDX_W-1:0]      ram_addr;
    pcpa_pkg::t_link                 ram_wdata;
    pcpa_pkg::t_link                 ram_rdata;
    logic                            bad;
    logic [pcpa_pkg::IDX_W-1:0]      free_idx;
    logic [pcpa_pkg::ADDR_W-1:0]     pop_addr;
    logic                            slot_ok;
    logic                            look_go;
    logic                            done_now;
    logic                            in_fire;

    pcpa_addr_unit u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_page_addr  (r_addr),
        .i_pop_idx    (r_pop_idx),
        .o_bad        (bad),
        .o_idx        (free_idx),
        .o_alloc_addr (pop_addr)
    );

    pcpa_head_table u_heads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cpu   (r_cpu),
        .i_wr    (head_wr),
        .o_pick  (pick)
    );

    pcpa_link_ram #(
        .WIDTH (pcpa_pkg::LINK_W),
        .DEPTH (pcpa_pkg::NUM_PAGES)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign slot_ok  = !r_out_vld || i_out_ready;
    assign look_go  = (r_state == S_LOOK) && slot_ok;
    assign done_now = look_go && !((r_req_type == pcpa_pkg::REQ_ALLOC) && pick.found);
    assign o_in_ready = (r_state == S_IDLE) || done_now || (r_state == S_POP);
    assign in_fire  = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_req_type   = r_req_type;
        n_cpu        = r_cpu;
        n_addr       = r_addr;
        n_pop_src    = r_pop_src;
        n_pop_idx    = r_pop_idx;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_served = r_out_served;
        head_wr      = '0;
        ram_we       = 1'b0;
        ram_addr     = pick.idx;
        ram_wdata    = pick.own;

        if (look_go) begin
            if (r_req_type == pcpa_pkg::REQ_FREE) begin
                n_out_vld    = 1'b1;
                n_out_addr   = '0;
                n_out_served = '0;
                if (bad) begin
                    n_out_status = pcpa_pkg::ST_BAD_FREE;
                end else begin
                    n_out_status     = pcpa_pkg::ST_OK;
                    ram_we           = 1'b1;
                    ram_addr         = free_idx;
                    head_wr.en       = 1'b1;
                    head_wr.cpu      = r_cpu;
                    head_wr.head.vld = 1'b1;
                    head_wr.head.idx = free_idx;
                end
            end else if (!pick.found) begin
                n_out_vld    = 1'b1;
                n_out_addr   = '0;
                n_out_served = '0;
                n_out_status = pcpa_pkg::ST_OOM;
            end else begin
                n_pop_src = pick.src;
                n_pop_idx = pick.idx;
                n_state   = S_POP;
            end
        end

        if (r_state == S_POP) begin
            head_wr.en   = 1'b1;
            head_wr.cpu  = r_pop_src;
            head_wr.head = ram_rdata;
            n_out_vld    = 1'b1;
            n_out_addr   = pop_addr;
            n_out_status = pcpa_pkg::ST_OK;
            n_out_served = r_pop_src;
        end

        if (in_fire) begin
            n_req_type = i_req_type;
            n_cpu      = i_cpu_id;
            n_addr     = i_page_addr;
            n_state    = S_LOOK;
        end else if (done_now || (r_state == S_POP)) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_req_type   <= n_req_type;
        r_cpu        <= n_cpu;
        r_addr       <= n_addr;
        r_pop_src    <= n_pop_src;
        r_pop_idx    <= n_pop_idx;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_served <= n_out_served;
    end

    assign o_out_valid  = r_out_vld;
    assign o_alloc_addr = r_out_addr;
    assign o_status     = r_out_status;
    assign o_served_cpu = r_out_served;

`ifndef SYNTHESIS
    a_pop_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !r_out_vld)
        else $error("pop step found result register occupied");

    a_pop_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> ($past(r_state) == S_LOOK))
        else $error("pop step not preceded by lookup");

    a_pop_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_out_vld && (r_out_status == pcpa_pkg::ST_OK)))
        else $error("pop step did not load a result");

    a_look_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOOK) && r_out_vld && !i_out_ready) |=> (r_state == S_LOOK))
        else $error("lookup advanced while result register was full");
`endif

endmodule

FILE: tb/sv/per_cpu_page_allocator_steal_test.sv
module per_cpu_page_allocator_steal_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [pcpa_pkg::ADDR_W-1:0]    t_addr;
    typedef logic [pcpa_pkg::CPU_W-1:0]     t_cpu;
    typedef logic [pcpa_pkg::IDX_W-1:0]     t_idx;
    typedef logic [pcpa_pkg::STATUS_W-1:0]  t_status;
    typedef logic [pcpa_pkg::CFG_IDX_W-1:0] t_cfg_idx;

    localparam longint unsigned ADDR_MAX = (64'd1 << pcpa_pkg::ADDR_W) - 1;
    localparam t_addr ADDR_ONES = '1;
    localparam int QUIET_LIMIT = 5000;

    typedef struct {
        t_addr   addr;
        t_status status;
        t_cpu    cpu;
    } t_page_result;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_addr    i_cfg_data;
    logic     i_in_valid;
    logic     o_in_ready;
    logic     i_req_type;
    t_cpu     i_cpu_id;
    t_addr    i_page_addr;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_addr    o_alloc_addr;
    t_status  o_status;
    t_cpu     o_served_cpu;

    per_cpu_page_allocator_steal dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint unsigned region_lo = 0;
    longint unsigned region_hi = 0;
    bit              list_top_vld [pcpa_pkg::NUM_CPUS];
    t_idx            list_top [pcpa_pkg::NUM_CPUS];
    bit              page_next_vld [pcpa_pkg::NUM_PAGES];
    t_idx            page_next [pcpa_pkg::NUM_PAGES];

    t_page_result pending_results [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;

    logic calm = 1'b0;
    logic stall_tog = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_len = 0;
    int   stall_left = 0;

    function automatic longint unsigned region_base();
        return (region_lo + pcpa_pkg::PAGE_BYTES - 1) / pcpa_pkg::PAGE_BYTES;
    endfunction

    function automatic t_addr page_at(input longint unsigned pidx);
        return t_addr'((region_base() + pidx) * pcpa_pkg::PAGE_BYTES);
    endfunction

    function automatic t_page_result predict_page_request(input logic rt,
                                                          input t_cpu cpu,
                                                          input t_addr addr);
        t_page_result    res;
        longint unsigned a;
        longint unsigned pidx;
        int              own;
        int              src;
        bit              found;
        res.addr   = '0;
        res.status = pcpa_pkg::ST_OK;
        res.cpu    = '0;
        a   = addr;
        own = cpu % pcpa_pkg::NUM_CPUS;
        if (rt == pcpa_pkg::REQ_FREE) begin
            if (a % pcpa_pkg::PAGE_BYTES != 0 || a < region_lo || a >= region_hi) begin
                res.status = pcpa_pkg::ST_BAD_FREE;
            end else begin
                pidx = a / pcpa_pkg::PAGE_BYTES - region_base();
                if (pidx >= pcpa_pkg::NUM_PAGES) begin
                    res.status = pcpa_pkg::ST_BAD_FREE;
                end else begin
                    page_next_vld[pidx] = list_top_vld[own];
                    page_next[pidx]     = list_top[own];
                    list_top_vld[own]   = 1'b1;
                    list_top[own]       = t_idx'(pidx);
                end
            end
        end else begin
            found = 1'b0;
            src   = own;
            for (int k = 0; k < pcpa_pkg::NUM_CPUS && !found; k++) begin
                src   = (own + k) % pcpa_pkg::NUM_CPUS;
                found = list_top_vld[src];
            end
            if (!found) begin
                res.status = pcpa_pkg::ST_OOM;
            end else begin
                pidx              = list_top[src] % pcpa_pkg::NUM_PAGES;
                list_top_vld[src] = page_next_vld[pidx];
                list_top[src]     = page_next[pidx];
                res.addr          = page_at(pidx);
                res.cpu           = t_cpu'(src);
            end
        end
        return res;
    endfunction

    task automatic send_request(input logic rt, input t_cpu cpu, input t_addr addr);
        while (!calm && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= rt;
        i_cpu_id    <= cpu;
        i_page_addr <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_page_request(rt, cpu, addr));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_region(input longint unsigned lo, input longint unsigned hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pcpa_pkg::CFG_REGION_START;
        i_cfg_data <= t_addr'(lo);
        @(posedge i_clk);
        i_cfg_idx  <= pcpa_pkg::CFG_REGION_END;
        i_cfg_data <= t_addr'(hi);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        region_lo = lo & ADDR_MAX;
        region_hi = hi & ADDR_MAX;
    endtask

    task automatic test_out_of_memory();
        set_region(64'h10_0000, 64'h10_0000 + 32 * pcpa_pkg::PAGE_BYTES);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd0, ADDR_ONES);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd7, '0);
        drain_results();
    endtask

    task automatic test_bad_free();
        set_region(64'h1800, ADDR_MAX);
        send_request(pcpa_pkg::REQ_FREE, 3'd1, 40'h2001);
        send_request(pcpa_pkg::REQ_FREE, 3'd1, 40'h1000);
        send_request(pcpa_pkg::REQ_FREE, 3'd1, 40'h0);
        send_request(pcpa_pkg::REQ_FREE, 3'd1, ADDR_ONES);
        send_request(pcpa_pkg::REQ_FREE, 3'd1, page_at(pcpa_pkg::NUM_PAGES));
        send_request(pcpa_pkg::REQ_FREE, 3'd7, page_at(pcpa_pkg::NUM_PAGES - 1));
        send_request(pcpa_pkg::REQ_ALLOC, 3'd7, '0);
        drain_results();
        set_region(64'h2000, 64'h4000);
        send_request(pcpa_pkg::REQ_FREE, 3'd2, 40'h4000);
        send_request(pcpa_pkg::REQ_FREE, 3'd2, 40'h3000);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd2, ADDR_ONES);
        drain_results();
    endtask

    task automatic test_steal_and_double_free();
        set_region(0, ADDR_MAX);
        send_request(pcpa_pkg::REQ_FREE, 3'd3, page_at(1));
        send_request(pcpa_pkg::REQ_FREE, 3'd3, page_at(2));
        send_request(pcpa_pkg::REQ_FREE, 3'd6, page_at(2));
        send_request(pcpa_pkg::REQ_ALLOC, 3'd3, '0);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd5, '0);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd4, '0);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd0, '0);
        drain_results();
    endtask

    task automatic test_region_moved();
        set_region(0, ADDR_MAX);
        send_request(pcpa_pkg::REQ_FREE, 3'd0, page_at(0));
        send_request(pcpa_pkg::REQ_FREE, 3'd1, page_at(5));
        drain_results();
        set_region(64'hFF_FFFF_F000, ADDR_MAX);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd1, '0);
        send_request(pcpa_pkg::REQ_ALLOC, 3'd0, '0);
        drain_results();
    endtask

    task automatic test_backpressure();
        set_region(0, ADDR_MAX);
        calm      <= 1'b1;
        stall_len <= 100;
        stall_tog <= ~stall_tog;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2) begin
                send_request(pcpa_pkg::REQ_ALLOC, t_cpu'($urandom_range(7)),
                             t_addr'({$urandom, $urandom}));
            end else begin
                send_request(pcpa_pkg::REQ_FREE, t_cpu'($urandom_range(7)),
                             page_at($urandom_range(63)));
            end
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input longint unsigned lo, input longint unsigned hi,
                                       input int span, input int count, input logic no_gaps);
        t_addr good;
        int    r;
        set_region(lo, hi);
        calm <= no_gaps;
        for (int i = 0; i < count; i++) begin
            r    = $urandom_range(99);
            good = page_at($urandom_range(span));
            if (r < 42) begin
                send_request(pcpa_pkg::REQ_ALLOC, t_cpu'($urandom_range(7)),
                             t_addr'({$urandom, $urandom}));
            end else if (r < 84) begin
                send_request(pcpa_pkg::REQ_FREE, t_cpu'($urandom_range(7)), good);
            end else if (r < 92) begin
                send_request(pcpa_pkg::REQ_FREE, t_cpu'($urandom_range(7)),
                             t_addr'({$urandom, $urandom}));
            end else begin
                send_request(pcpa_pkg::REQ_FREE, t_cpu'($urandom_range(7)),
                             t_addr'(good + $urandom_range(pcpa_pkg::PAGE_BYTES - 1, 1)));
            end
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (stall_tog != stall_seen) begin
            stall_seen  <= stall_tog;
            stall_left  <= stall_len;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: addr %h status %0d cpu %0d",
                             o_alloc_addr, o_status, o_served_cpu);
            end else begin
                want = pending_results.pop_front();
                if (o_alloc_addr !== want.addr || o_status !== want.status ||
                    o_served_cpu !== want.cpu) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: addr %h/%h status %0d/%0d cpu %0d/%0d (exp/act)",
                                 want.addr, o_alloc_addr, want.status, o_status,
                                 want.cpu, o_served_cpu);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[per_cpu_page_allocator_steal] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= pcpa_pkg::CFG_REGION_START;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_req_type  <= pcpa_pkg::REQ_ALLOC;
        i_cpu_id    <= '0;
        i_page_addr <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_out_of_memory();
        test_bad_free();
        test_steal_and_double_free();
        test_region_moved();
        test_backpressure();
        test_random_traffic(0, ADDR_MAX, 40, 100, 1'b0);
        test_random_traffic(64'h1800, 64'h1800 + 200 * pcpa_pkg::PAGE_BYTES, 220, 100, 1'b1);
        test_random_traffic(64'hFF_FFF0_0000, ADDR_MAX, 260, 100, 1'b0);
        test_random_traffic(0, 0, 16, 30, 1'b0);
        test_random_traffic(0, ADDR_MAX, pcpa_pkg::NUM_PAGES + 100, 70, 1'b0);

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[per_cpu_page_allocator_steal] OK");
        end else begin
            $display("[per_cpu_page_allocator_steal] ERROR");
        end
        $finish;
    end

endmodule
